// ===== sv/helmert_point_residual_assert.svh =====
// ----------------------------------------------------------------------------
// helmert_point_residual assertion macros
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HELMERT_POINT_RESIDUAL_ASSERT_SVH
`define HELMERT_POINT_RESIDUAL_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define HPR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define HPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/hpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hpr_pkg
// Types, widths and helpers shared by the Helmert residual block.
// ----------------------------------------------------------------------------
package hpr_pkg;

    localparam int CW      = 48;          // coordinate width
    localparam int FRAC    = 30;          // Q2.30 fraction bits
    localparam int MW      = 32;          // matrix entry width
    localparam int SCL_W   = 32;
    localparam int IDX_W   = 3;

    localparam int SRC_LO_W = CW / 2;
    localparam int SRC_HI_W = CW - SRC_LO_W;
    localparam int PL_W     = MW + SRC_LO_W + 1;
    localparam int PH_W     = MW + SRC_HI_W;
    localparam int PROD_W   = MW + CW;
    localparam int ACC_W    = PROD_W + 2;
    localparam int RACC_W   = ACC_W - FRAC;
    localparam int ACC_LO_W = RACC_W / 2;
    localparam int ACC_HI_W = RACC_W - ACC_LO_W;
    localparam int QL_W     = ACC_LO_W + SCL_W + 1;
    localparam int QH_W     = ACC_HI_W + SCL_W + 1;
    localparam int SP_W     = RACC_W + SCL_W + 1;
    localparam int SC_W     = SP_W - FRAC;
    localparam int D_W      = CW + 1;
    localparam int T_W      = SC_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(2 ** (FRAC - 1));
    localparam logic signed [SP_W-1:0]  SP_RND  = SP_W'(2 ** (FRAC - 1));
    localparam logic signed [MW-1:0]    ONE_Q30 = MW'(2 ** FRAC);
    localparam logic [SCL_W-1:0]        SCALE_ONE = SCL_W'(2 ** FRAC);

    typedef enum logic [IDX_W-1:0] {
        REG_SHIFT_X = 3'd0,
        REG_SHIFT_Y = 3'd1,
        REG_SHIFT_Z = 3'd2,
        REG_ANGLE_X = 3'd3,
        REG_ANGLE_Y = 3'd4,
        REG_ANGLE_Z = 3'd5,
        REG_SCALE   = 3'd6
    } cfg_reg_t;

    typedef logic signed [MW-1:0] mat_entry_t;
    typedef mat_entry_t [8:0]     mat_t;
    typedef logic [2:0][31:0]     ang_vec_t;

    typedef struct packed {
        logic signed [CW-1:0] src_x;
        logic signed [CW-1:0] src_y;
        logic signed [CW-1:0] src_z;
        logic signed [CW-1:0] dst_x;
        logic signed [CW-1:0] dst_y;
        logic signed [CW-1:0] dst_z;
    } in_t;

    typedef struct packed {
        logic signed [CW-1:0] resid_x;
        logic signed [CW-1:0] resid_y;
        logic signed [CW-1:0] resid_z;
    } out_t;

    typedef struct packed {
        logic busy;
        mat_t mat;
    } rot_status_t;

    // clamp to [-1, 1] in Q2.30
    function automatic mat_entry_t clamp_q30(input logic signed [35:0] v);
        mat_entry_t r;
        if (v > 36'(ONE_Q30)) begin
            r = ONE_Q30;
        end else if (v < -36'(ONE_Q30)) begin
            r = -ONE_Q30;
        end else begin
            r = MW'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/hpr_rot.sv =====
// ----------------------------------------------------------------------------
// hpr_rot
// Rotation matrix sequencer: shared CORDIC for the three angles, then one
// Q2.30 multiplier stepping through the matrix products.
// ----------------------------------------------------------------------------
module hpr_rot (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  hpr_pkg::ang_vec_t    angles,
    output hpr_pkg::rot_status_t status
);
    import hpr_pkg::*;

    typedef enum logic [2:0] {
        R_IDLE, R_LOAD, R_ITER, R_STORE, R_MAT, R_COMMIT
    } rstate_t;

    localparam logic signed [33:0] CORDIC_X0 = 34'sh26DD3B6A;

    rstate_t                  state_reg;
    logic signed [33:0]       x_reg, y_reg;
    logic signed [31:0]       z_reg;
    logic [4:0]               iter_reg;
    logic [1:0]               axis_reg;
    logic [3:0]               step_reg;
    mat_entry_t               sin_reg [3];
    mat_entry_t               cos_reg [3];
    logic signed [32:0]       prod_reg [14];
    mat_t                     mat_reg;

    logic signed [31:0]       atan_v;
    logic signed [33:0]       x_next, y_next;
    logic signed [31:0]       z_next;
    logic [31:0]              ang;
    logic signed [33:0]       xf, yf;
    mat_entry_t               xc, yc, s_next, c_next;
    logic signed [32:0]       op_a, op_b;
    logic signed [65:0]       qprod;
    mat_t                     mat_next;

    always_comb begin
        case (iter_reg)
            5'd0:  atan_v = 32'sd536870912;
            5'd1:  atan_v = 32'sd316933406;
            5'd2:  atan_v = 32'sd167458907;
            5'd3:  atan_v = 32'sd85004756;
            5'd4:  atan_v = 32'sd42667331;
            5'd5:  atan_v = 32'sd21354465;
            5'd6:  atan_v = 32'sd10680862;
            5'd7:  atan_v = 32'sd5340245;
            5'd8:  atan_v = 32'sd2670163;
            5'd9:  atan_v = 32'sd1335087;
            5'd10: atan_v = 32'sd667544;
            5'd11: atan_v = 32'sd333772;
            5'd12: atan_v = 32'sd166886;
            5'd13: atan_v = 32'sd83443;
            5'd14: atan_v = 32'sd41722;
            5'd15: atan_v = 32'sd20861;
            5'd16: atan_v = 32'sd10430;
            5'd17: atan_v = 32'sd5215;
            5'd18: atan_v = 32'sd2608;
            5'd19: atan_v = 32'sd1304;
            5'd20: atan_v = 32'sd652;
            5'd21: atan_v = 32'sd326;
            5'd22: atan_v = 32'sd163;
            5'd23: atan_v = 32'sd81;
            5'd24: atan_v = 32'sd41;
            5'd25: atan_v = 32'sd20;
            5'd26: atan_v = 32'sd10;
            5'd27: atan_v = 32'sd5;
            5'd28: atan_v = 32'sd3;
            5'd29: atan_v = 32'sd1;
            default: atan_v = 32'sd0;
        endcase
    end

    always_comb begin
        if (z_reg >= 0) begin
            x_next = x_reg - (y_reg >>> iter_reg);
            y_next = y_reg + (x_reg >>> iter_reg);
            z_next = z_reg - atan_v;
        end else begin
            x_next = x_reg + (y_reg >>> iter_reg);
            y_next = y_reg - (x_reg >>> iter_reg);
            z_next = z_reg + atan_v;
        end
    end

    // final CORDIC vector to sine and cosine of the full angle
    always_comb begin
        ang = angles[axis_reg];
        if (ang[29:0] == 30'd0) begin
            xf = 34'(ONE_Q30);
            yf = '0;
        end else begin
            xf = x_reg;
            yf = y_reg;
        end
        xc = clamp_q30(36'(xf));
        yc = clamp_q30(36'(yf));
        case (ang[31:30])
            2'd0:    begin c_next = xc;  s_next = yc;  end
            2'd1:    begin c_next = -yc; s_next = xc;  end
            2'd2:    begin c_next = -xc; s_next = -yc; end
            default: begin c_next = yc;  s_next = -xc; end
        endcase
    end

    // operand selection per matrix step
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (step_reg)
            4'd0:  begin op_a = 33'(sin_reg[0]); op_b = 33'(sin_reg[1]); end
            4'd1:  begin op_a = 33'(cos_reg[0]); op_b = 33'(sin_reg[1]); end
            4'd2:  begin op_a = 33'(cos_reg[1]); op_b = 33'(cos_reg[2]); end
            4'd3:  begin op_a = prod_reg[0];     op_b = 33'(cos_reg[2]); end
            4'd4:  begin op_a = 33'(cos_reg[0]); op_b = 33'(sin_reg[2]); end
            4'd5:  begin op_a = prod_reg[1];     op_b = 33'(cos_reg[2]); end
            4'd6:  begin op_a = 33'(sin_reg[0]); op_b = 33'(sin_reg[2]); end
            4'd7:  begin op_a = 33'(cos_reg[1]); op_b = 33'(sin_reg[2]); end
            4'd8:  begin op_a = prod_reg[0];     op_b = 33'(sin_reg[2]); end
            4'd9:  begin op_a = 33'(cos_reg[0]); op_b = 33'(cos_reg[2]); end
            4'd10: begin op_a = prod_reg[1];     op_b = 33'(sin_reg[2]); end
            4'd11: begin op_a = 33'(sin_reg[0]); op_b = 33'(cos_reg[2]); end
            4'd12: begin op_a = 33'(sin_reg[0]); op_b = 33'(cos_reg[1]); end
            4'd13: begin op_a = 33'(cos_reg[0]); op_b = 33'(cos_reg[1]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
        qprod = ((66'(op_a) * 66'(op_b)) + 66'(2 ** (FRAC - 1))) >>> FRAC;
    end

    always_comb begin
        mat_next[0] = clamp_q30(36'(prod_reg[2]));
        mat_next[1] = clamp_q30(36'(prod_reg[3]) + 36'(prod_reg[4]));
        mat_next[2] = clamp_q30(36'(prod_reg[6]) - 36'(prod_reg[5]));
        mat_next[3] = clamp_q30(-36'(prod_reg[7]));
        mat_next[4] = clamp_q30(36'(prod_reg[9]) - 36'(prod_reg[8]));
        mat_next[5] = clamp_q30(36'(prod_reg[10]) + 36'(prod_reg[11]));
        mat_next[6] = sin_reg[1];
        mat_next[7] = clamp_q30(-36'(prod_reg[12]));
        mat_next[8] = clamp_q30(36'(prod_reg[13]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            axis_reg  <= '0;
            iter_reg  <= '0;
            step_reg  <= '0;
            for (int i = 0; i < 9; i++) begin
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q30 : '0;
            end
        end else if (start) begin
            // restart from the first angle with the latest values
            state_reg <= R_LOAD;
            axis_reg  <= '0;
        end else begin
            case (state_reg)
                R_IDLE: begin
                end
                R_LOAD: begin
                    x_reg     <= CORDIC_X0;
                    y_reg     <= '0;
                    z_reg     <= 32'({2'b00, ang[29:0]});
                    iter_reg  <= '0;
                    state_reg <= R_ITER;
                end
                R_ITER: begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'd29) begin
                        state_reg <= R_STORE;
                    end
                end
                R_STORE: begin
                    sin_reg[axis_reg] <= s_next;
                    cos_reg[axis_reg] <= c_next;
                    if (axis_reg == 2'd2) begin
                        step_reg  <= '0;
                        state_reg <= R_MAT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= R_LOAD;
                    end
                end
                R_MAT: begin
                    prod_reg[step_reg] <= 33'(qprod);
                    step_reg           <= step_reg + 4'd1;
                    if (step_reg == 4'd13) begin
                        state_reg <= R_COMMIT;
                    end
                end
                R_COMMIT: begin
                    mat_reg   <= mat_next;
                    state_reg <= R_IDLE;
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    assign status.busy = (state_reg != R_IDLE);
    assign status.mat  = mat_reg;

endmodule

// ===== sv/hpr_pipe.sv =====
// ----------------------------------------------------------------------------
// hpr_pipe
// Six-stage point datapath: rotate, round, scale, round, subtract, saturate.
// ----------------------------------------------------------------------------
module hpr_pipe (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  hpr_pkg::in_t               in_data,
    output logic                       in_ready,
    input  hpr_pkg::mat_t              mat,
    input  logic signed [hpr_pkg::CW-1:0] shift_x,
    input  logic signed [hpr_pkg::CW-1:0] shift_y,
    input  logic signed [hpr_pkg::CW-1:0] shift_z,
    input  logic [hpr_pkg::SCL_W-1:0]  scale,
    output logic                       m_valid,
    input  logic                       m_ready,
    output hpr_pkg::out_t              m_data
);
    import hpr_pkg::*;

    localparam int NST = 6;

    logic [NST:1]  vld_reg;
    logic [NST+1:1] adv;

    logic signed [CW-1:0]     src [3];
    logic signed [CW-1:0]     dst_in [3];
    logic signed [CW-1:0]     shf [3];

    logic signed [PL_W-1:0]   pl_reg [9];
    logic signed [PH_W-1:0]   ph_reg [9];
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [RACC_W-1:0] racc_reg [3];
    logic signed [QL_W-1:0]   ql_reg [3];
    logic signed [QH_W-1:0]   qh_reg [3];
    logic signed [SC_W-1:0]   sc_reg [3];
    logic signed [D_W-1:0]    d_reg [3];
    logic signed [CW-1:0]     res_reg [3];
    logic signed [CW-1:0]     dst1_reg [3], dst2_reg [3], dst3_reg [3], dst4_reg [3];

    logic signed [PL_W-1:0]   pl_next [9];
    logic signed [PH_W-1:0]   ph_next [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [ACC_W-1:0]  sum_next [3];
    logic signed [QL_W-1:0]   ql_next [3];
    logic signed [QH_W-1:0]   qh_next [3];
    logic signed [SP_W-1:0]   sp_next [3];
    logic signed [T_W-1:0]    t_next [3];
    logic signed [CW-1:0]     res_next [3];

    assign src[0]    = in_data.src_x;
    assign src[1]    = in_data.src_y;
    assign src[2]    = in_data.src_z;
    assign dst_in[0] = in_data.dst_x;
    assign dst_in[1] = in_data.dst_y;
    assign dst_in[2] = in_data.dst_z;
    assign shf[0]    = shift_x;
    assign shf[1]    = shift_y;
    assign shf[2]    = shift_z;

    // a stage advances when empty or when the stage after it advances
    always_comb begin
        adv[NST+1] = m_ready;
        for (int k = NST; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end
    assign in_ready = adv[1];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                pl_next[r*3+j] = $signed(mat[r*3+j])
                               * $signed({1'b0, src[j][SRC_LO_W-1:0]});
                ph_next[r*3+j] = $signed(mat[r*3+j]) * $signed(src[j][CW-1:SRC_LO_W]);
            end
        end
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = (PROD_W'(ph_reg[i]) <<< SRC_LO_W) + PROD_W'(pl_reg[i]);
        end
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = ACC_W'(prod_reg[r*3]) + ACC_W'(prod_reg[r*3+1])
                        + ACC_W'(prod_reg[r*3+2]) + ACC_RND;
            ql_next[r] = $signed({1'b0, racc_reg[r][ACC_LO_W-1:0]})
                       * $signed({1'b0, scale});
            qh_next[r] = $signed(racc_reg[r][RACC_W-1:ACC_LO_W]) * $signed({1'b0, scale});
            sp_next[r] = (SP_W'(qh_reg[r]) <<< ACC_LO_W) + SP_W'(ql_reg[r]) + SP_RND;
            t_next[r]  = T_W'(d_reg[r]) - T_W'(sc_reg[r]);
            // saturate when the bits above the sign disagree
            if (t_next[r][T_W-1:CW-1] != {(T_W-CW+1){t_next[r][T_W-1]}}) begin
                res_next[r] = t_next[r][T_W-1] ? {1'b1, {(CW-1){1'b0}}}
                                               : {1'b0, {(CW-1){1'b1}}};
            end else begin
                res_next[r] = t_next[r][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) vld_reg[1] <= take;
            for (int k = 2; k <= NST; k++) begin
                if (adv[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < 9; i++) begin
                pl_reg[i] <= pl_next[i];
                ph_reg[i] <= ph_next[i];
            end
            for (int r = 0; r < 3; r++) dst1_reg[r] <= dst_in[r];
        end
        if (adv[2]) begin
            for (int i = 0; i < 9; i++) prod_reg[i] <= prod_next[i];
            for (int r = 0; r < 3; r++) dst2_reg[r] <= dst1_reg[r];
        end
        if (adv[3]) begin
            for (int r = 0; r < 3; r++) begin
                racc_reg[r] <= RACC_W'(sum_next[r] >>> FRAC);
                dst3_reg[r] <= dst2_reg[r];
            end
        end
        if (adv[4]) begin
            for (int r = 0; r < 3; r++) begin
                ql_reg[r]   <= ql_next[r];
                qh_reg[r]   <= qh_next[r];
                dst4_reg[r] <= dst3_reg[r];
            end
        end
        if (adv[5]) begin
            for (int r = 0; r < 3; r++) begin
                sc_reg[r] <= SC_W'(sp_next[r] >>> FRAC);
                d_reg[r]  <= D_W'(dst4_reg[r]) - D_W'(shf[r]);
            end
        end
        if (adv[6]) begin
            for (int r = 0; r < 3; r++) res_reg[r] <= res_next[r];
        end
    end

    assign m_valid        = vld_reg[NST];
    assign m_data.resid_x = res_reg[0];
    assign m_data.resid_y = res_reg[1];
    assign m_data.resid_z = res_reg[2];

endmodule

// ===== sv/helmert_point_residual.sv =====
// ----------------------------------------------------------------------------
// helmert_point_residual
// Seven-parameter similarity transform residual, dst - (T + s * R * src).
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   in_t  (src xyz, dst xyz)
//  m_       out        m_valid / m_ready   out_t (resid xyz)
//  cfg_     in         cfg_wen             cfg_idx, cfg_wdata
//
//  One point pair per cycle while s_ready is high; each result passes through the registered datapath stages.
//  An angle write rebuilds the matrix (one CORDIC run per angle on the
//  shared rotator, 14 multiplier steps, one commit); s_ready stays low meanwhile.
//  Reset loads the identity matrix, zero shifts and unit scale.
//  A stall at m_ready holds the output; upstream stages keep filling bubbles.
// ----------------------------------------------------------------------------
module helmert_point_residual (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hpr_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hpr_pkg::out_t                 m_data,
    input  logic                          cfg_wen,
    input  logic [hpr_pkg::IDX_W-1:0]     cfg_idx,
    input  logic [hpr_pkg::CW-1:0]        cfg_wdata
);
    import hpr_pkg::*;

`include "helmert_point_residual_assert.svh"

    logic signed [CW-1:0] shift_x_reg, shift_y_reg, shift_z_reg;
    ang_vec_t             angle_reg;
    logic [SCL_W-1:0]     scale_reg;
    logic                 angle_wr;
    logic                 pipe_ready;
    logic                 take;
    rot_status_t          rot;

    assign angle_wr = cfg_wen && (cfg_idx == REG_ANGLE_X || cfg_idx == REG_ANGLE_Y
                                  || cfg_idx == REG_ANGLE_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            shift_z_reg <= '0;
            angle_reg   <= '0;
            scale_reg   <= SCALE_ONE;
        end else if (cfg_wen) begin
            case (cfg_idx)
                REG_SHIFT_X: shift_x_reg  <= cfg_wdata;
                REG_SHIFT_Y: shift_y_reg  <= cfg_wdata;
                REG_SHIFT_Z: shift_z_reg  <= cfg_wdata;
                REG_ANGLE_X: angle_reg[0] <= cfg_wdata[31:0];
                REG_ANGLE_Y: angle_reg[1] <= cfg_wdata[31:0];
                REG_ANGLE_Z: angle_reg[2] <= cfg_wdata[31:0];
                REG_SCALE:   scale_reg    <= cfg_wdata[SCL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hpr_rot u_rot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (angle_wr),
        .angles  (angle_reg),
        .status  (rot)
    );

    // hold input while the matrix is rebuilt
    assign s_ready = pipe_ready && !rot.busy && !angle_wr;
    assign take    = s_valid && s_ready;

    hpr_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .in_data  (s_data),
        .in_ready (pipe_ready),
        .mat      (rot.mat),
        .shift_x  (shift_x_reg),
        .shift_y  (shift_y_reg),
        .shift_z  (shift_z_reg),
        .scale    (scale_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `HPR_ASSERT_SAME(a_no_take_rebuild, aclk, aresetn, rot.busy, !(s_valid && s_ready))
    `HPR_ASSERT_NEXT(a_angle_starts, aclk, aresetn, angle_wr, rot.busy)

endmodule
